>>> design/tfx_pkg.sv
// shared constants and types of the two-wire frame transceiver
package tfx_pkg;

  localparam int DATA_BYTES = 8;
  localparam int FRAME_LEN  = DATA_BYTES + 4;
  localparam int IDX_W      = $clog2(FRAME_LEN);
  localparam int POS_W      = $clog2(FRAME_LEN + 1);
  localparam int CNT_W      = 24;
  localparam int TICK_W     = 20;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_EDGE = 2'd1;
  localparam logic [1:0] FUNC_SEND = 2'd2;

  localparam logic [1:0] REG_TICK_NS       = 2'd0;
  localparam logic [1:0] REG_RX_TIMEOUT_NS = 2'd1;
  localparam logic [1:0] REG_BIT_HALF_NS   = 2'd2;

  localparam logic [TICK_W-1:0] TICK_NS_RST       = TICK_W'(1000);
  localparam logic [CNT_W-1:0]  RX_TIMEOUT_NS_RST = CNT_W'(1000000);
  localparam logic [CNT_W-1:0]  BIT_HALF_NS_RST   = CNT_W'(50000);

  typedef struct packed {
    logic [1:0] func;
    logic       sda_level;
    logic [7:0] send_byte;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       drive_enable;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       rx_last;
    logic       send_rejected;
    logic [1:0] link_mode;
  } out_item_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick_ns;
    logic [CNT_W-1:0]  rx_timeout_ns;
    logic [CNT_W-1:0]  bit_half_ns;
  } cfg_regs_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic emit_status;
    logic burst_first;
    logic burst_emit;
    logic burst_hold;
  } ctrl_cmd_t;

  typedef struct packed {
    logic burst_req;
    logic burst_last;
  } dp_status_t;

endpackage

>>> design/tfx_regs.sv
// configuration register file with its apb-style access port
module tfx_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tfx_pkg::ADDR_W-1:0] paddr,
  input  logic [tfx_pkg::DATA_W-1:0] pwdata,
  output logic [tfx_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output tfx_pkg::cfg_regs_t         cfg
);
  import tfx_pkg::*;

  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [CNT_W-1:0]  tmo_r, tmo_nxt;
  logic [CNT_W-1:0]  half_r, half_nxt;
  logic              wr_en;
  logic [1:0]        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[ADDR_W-1:2];

  always_comb begin
    tick_nxt = tick_r;
    tmo_nxt  = tmo_r;
    half_nxt = half_r;
    prdata   = '0;
    unique case (reg_sel)
      REG_TICK_NS: begin
        prdata = DATA_W'(tick_r);
        if (wr_en) tick_nxt = pwdata[TICK_W-1:0];
      end
      REG_RX_TIMEOUT_NS: begin
        prdata = DATA_W'(tmo_r);
        if (wr_en) tmo_nxt = pwdata[CNT_W-1:0];
      end
      REG_BIT_HALF_NS: begin
        prdata = DATA_W'(half_r);
        if (wr_en) half_nxt = pwdata[CNT_W-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= TICK_NS_RST;
      tmo_r  <= RX_TIMEOUT_NS_RST;
      half_r <= BIT_HALF_NS_RST;
    end else begin
      tick_r <= tick_nxt;
      tmo_r  <= tmo_nxt;
      half_r <= half_nxt;
    end
  end

  assign cfg.tick_ns       = tick_r;
  assign cfg.rx_timeout_ns = tmo_r;
  assign cfg.bit_half_ns   = half_r;

endmodule

>>> design/tfx_ctrl.sv
// controller: sequences accept, execute, result and frame readout burst
module tfx_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tfx_pkg::dp_status_t status,
  output tfx_pkg::ctrl_cmd_t  cmd
);
  import tfx_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT,
    S_BSTART,
    S_BURST
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = status.burst_req ? S_BSTART : S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit_status = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_BSTART: begin
        cmd.burst_first = 1'b1;
        state_nxt       = S_BURST;
      end
      S_BURST: begin
        if (slot_free) begin
          cmd.burst_emit = 1'b1;
          out_valid_nxt  = 1'b1;
          if (status.burst_last) state_nxt = S_IDLE;
        end else begin
          cmd.burst_hold = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> design/tfx_dpath.sv
// datapath: link phase, timer, bit and byte counters, frame store, result register
module tfx_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  tfx_pkg::in_item_t   in_data,
  input  tfx_pkg::ctrl_cmd_t  cmd,
  input  tfx_pkg::cfg_regs_t  cfg,
  output tfx_pkg::dp_status_t status,
  output tfx_pkg::out_item_t  out_data
);
  import tfx_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RECV,
    PH_LOAD,
    PH_HIGH,
    PH_LOW,
    PH_LAST
  } phase_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_TIMEOUT,
    ACT_SEND
  } action_t;

  localparam logic [POS_W-1:0] FRAME_END = POS_W'(FRAME_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FRAME_LEN - 1);

  phase_t            phase_r, phase_nxt;
  action_t           pend_r, pend_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  reload_r, reload_nxt;
  logic [2:0]        bitp_r, bitp_nxt;
  logic [POS_W-1:0]  bytep_r, bytep_nxt;
  logic [7:0]        asm_r, asm_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic              drv_r, drv_nxt;
  logic              rej_r, rej_nxt;
  logic [IDX_W-1:0]  bidx_r;
  logic [7:0]        rd_data_r;
  in_item_t          item_r;
  out_item_t         out_r;

  logic [7:0]        mem [FRAME_LEN];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [7:0]        mem_wd;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;

  logic [POS_W-1:0]  bp_inc;
  logic [IDX_W-1:0]  byte_idx;
  logic [CNT_W-1:0]  tick_ext;
  logic              done;
  logic [1:0]        mode;

  assign bp_inc   = bytep_r + POS_W'(1);
  assign byte_idx = (bytep_r < FRAME_END) ? bytep_r[IDX_W-1:0] : '0;
  assign tick_ext = CNT_W'(cfg.tick_ns);

  always_comb begin
    unique case (phase_r)
      PH_IDLE: mode = 2'd0;
      PH_RECV: mode = 2'd1;
      PH_LOAD: mode = 2'd2;
      default: mode = 2'd3;
    endcase
  end

  // one transaction's effect on the link state
  always_comb begin
    logic [POS_W-1:0] bp_new;
    logic             taken;
    phase_nxt  = phase_r;
    pend_nxt   = pend_r;
    cnt_nxt    = cnt_r;
    reload_nxt = reload_r;
    bitp_nxt   = bitp_r;
    bytep_nxt  = bytep_r;
    asm_nxt    = asm_r;
    scl_nxt    = scl_r;
    sda_nxt    = sda_r;
    drv_nxt    = drv_r;
    rej_nxt    = rej_r;
    mem_we     = 1'b0;
    mem_wa     = byte_idx;
    mem_wd     = item_r.send_byte;
    done       = 1'b0;
    bp_new     = bp_inc;
    taken      = 1'b1;
    if (cmd.exec) begin
      rej_nxt = 1'b0;
      case (item_r.func)
        FUNC_TICK: begin
          if (tick_ext >= cnt_r) begin
            cnt_nxt = '0;
            if (pend_r == ACT_TIMEOUT) begin
              phase_nxt = PH_IDLE;
              pend_nxt  = ACT_NONE;
              bitp_nxt  = '0;
              bytep_nxt = '0;
            end else if (pend_r == ACT_SEND) begin
              if (phase_r == PH_HIGH) begin
                phase_nxt = PH_LOW;
                sda_nxt   = (bytep_r < FRAME_END) && rd_data_r[bitp_r];
                scl_nxt   = 1'b0;
                bitp_nxt  = bitp_r + 3'd1;
                cnt_nxt   = reload_r;
                if (bitp_r == 3'd7) begin
                  bytep_nxt = bp_inc;
                  if (bp_inc >= FRAME_END) phase_nxt = PH_LAST;
                end
              end else if (phase_r == PH_LOW) begin
                phase_nxt = PH_HIGH;
                scl_nxt   = 1'b1;
                cnt_nxt   = reload_r;
              end else if (phase_r == PH_LAST) begin
                // end of transmission: release lines, counter not reloaded
                bitp_nxt  = '0;
                bytep_nxt = '0;
                pend_nxt  = ACT_NONE;
                phase_nxt = PH_IDLE;
                drv_nxt   = 1'b0;
                scl_nxt   = 1'b1;
              end else begin
                pend_nxt = ACT_NONE;
              end
            end
          end else begin
            cnt_nxt = cnt_r - tick_ext;
          end
        end
        FUNC_EDGE: begin
          if (phase_r == PH_IDLE || phase_r == PH_RECV) begin
            phase_nxt  = PH_RECV;
            pend_nxt   = ACT_TIMEOUT;
            reload_nxt = cfg.rx_timeout_ns;
            cnt_nxt    = cfg.rx_timeout_ns;
            asm_nxt    = {item_r.sda_level, asm_r[7:1]};
            bitp_nxt   = bitp_r + 3'd1;
            if (bitp_r == 3'd7) begin
              mem_we    = (bytep_r < FRAME_END);
              mem_wd    = asm_nxt;
              bytep_nxt = bp_inc;
              if (bp_inc >= FRAME_END) begin
                done      = 1'b1;
                bitp_nxt  = '0;
                bytep_nxt = '0;
              end
            end
          end
        end
        FUNC_SEND: begin
          if (phase_r == PH_IDLE) begin
            phase_nxt = PH_LOAD;
            bitp_nxt  = '0;
            mem_we    = 1'b1;
            mem_wa    = '0;
            bp_new    = POS_W'(1);
          end else if (phase_r == PH_LOAD) begin
            mem_we = (bytep_r < FRAME_END);
            bp_new = bp_inc;
          end else begin
            taken   = 1'b0;
            rej_nxt = 1'b1;
          end
          if (taken) begin
            bytep_nxt = bp_new;
            if (bp_new >= FRAME_END) begin
              phase_nxt  = PH_HIGH;
              drv_nxt    = 1'b1;
              bitp_nxt   = '0;
              bytep_nxt  = '0;
              pend_nxt   = ACT_SEND;
              reload_nxt = cfg.bit_half_ns;
              cnt_nxt    = '0;
            end
          end
        end
        default: rej_nxt = 1'b0;
      endcase
    end
  end

  assign status.burst_req  = done;
  assign status.burst_last = (bidx_r == LAST_IDX);

  // store read port follows the send pointer, or the burst index during readout
  assign rd_en = !cmd.burst_hold;
  always_comb begin
    if (cmd.burst_first) begin
      rd_addr = '0;
    end else if (cmd.burst_emit) begin
      rd_addr = (bidx_r == LAST_IDX) ? '0 : bidx_r + IDX_W'(1);
    end else begin
      rd_addr = byte_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      pend_r   <= ACT_NONE;
      cnt_r    <= '0;
      reload_r <= '0;
      bitp_r   <= '0;
      bytep_r  <= '0;
      scl_r    <= 1'b1;
      sda_r    <= 1'b1;
      drv_r    <= 1'b0;
      rej_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      pend_r   <= pend_nxt;
      cnt_r    <= cnt_nxt;
      reload_r <= reload_nxt;
      bitp_r   <= bitp_nxt;
      bytep_r  <= bytep_nxt;
      scl_r    <= scl_nxt;
      sda_r    <= sda_nxt;
      drv_r    <= drv_nxt;
      rej_r    <= rej_nxt;
    end
  end

  always_ff @(posedge clk) begin
    asm_r <= asm_nxt;
    if (cmd.accept) item_r <= in_data;
    if (cmd.burst_first) begin
      bidx_r <= '0;
    end else if (cmd.burst_emit && bidx_r != LAST_IDX) begin
      bidx_r <= bidx_r + IDX_W'(1);
    end
    if (cmd.emit_status || cmd.burst_emit) begin
      out_r.scl_out       <= scl_r;
      out_r.sda_out       <= sda_r;
      out_r.drive_enable  <= drv_r;
      out_r.link_mode     <= mode;
      out_r.rx_byte       <= cmd.burst_emit ? rd_data_r : 8'd0;
      out_r.rx_valid      <= cmd.burst_emit;
      out_r.rx_last       <= cmd.burst_emit && status.burst_last;
      out_r.send_rejected <= cmd.emit_status && rej_r;
    end
  end

  assign out_data = out_r;

endmodule

>>> design/two_wire_frame_transceiver_unit.sv
// top level of the two-wire frame transceiver
//
// in_* channel: one transaction per event (timer tick, falling clock edge
// seen on the line, or one frame byte offered for sending). out_* channel:
// status transactions carrying driven line levels, drive enable, link mode
// and send rejection; a frame of 3 header bytes, the data bytes and a check
// byte that completes on receive comes out as a burst of byte transactions,
// the final one marked with rx_last.
// An item is taken, executed and its result registered in turn, through the
// accept, execute and result states; the next item is taken only once that
// result is registered. An edge that completes a frame is then read out,
// walking the frame store through its single registered read port.
// The apb port (psel/penable/pwrite/paddr/pwdata) sets tick length, receive
// timeout and half bit period; write it only while the link is quiet.
// Reset (rst_n low, synchronous) sets the link idle with both lines released
// high and the registers at their default values; no clearing pass is run.
// If out_ready stays low the result waits in the output register and the
// block holds after taking at most one more item, without dropping anything.
module two_wire_frame_transceiver_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  tfx_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output tfx_pkg::out_item_t         out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tfx_pkg::ADDR_W-1:0] paddr,
  input  logic [tfx_pkg::DATA_W-1:0] pwdata,
  output logic [tfx_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import tfx_pkg::*;

  cfg_regs_t  cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  tfx_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tfx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tfx_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .cfg      (cfg),
    .status   (status),
    .out_data (out_data)
  );

endmodule

>>> tb/tfx_checker.sv
// checker for the two-wire frame transceiver: predicts every result and compares it
`timescale 1ns / 100ps
module tfx_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  tfx_pkg::in_item_t          in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  tfx_pkg::out_item_t         out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tfx_pkg::ADDR_W-1:0] paddr,
  input  logic [tfx_pkg::DATA_W-1:0] pwdata,
  input  logic [tfx_pkg::DATA_W-1:0] prdata,
  input  logic                       pready,
  output int                         fail_count,
  output int                         pending,
  output logic                       link_idle,
  output logic                       link_loading,
  output int                         result_count,
  output int                         frame_count,
  output int                         reject_count,
  output int                         xmit_count
);
  import tfx_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RECV, ST_LOAD, ST_HIGH, ST_LOW, ST_LAST
  } link_phase_t;

  typedef enum logic [1:0] {
    ACT_NONE, ACT_TIMEOUT, ACT_SEND
  } timer_act_t;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_RECV = 2'd1;
  localparam logic [1:0] MODE_LOAD = 2'd2;
  localparam logic [1:0] MODE_XMIT = 2'd3;

  // mirrored registers
  logic [TICK_W-1:0] tick_len;
  logic [CNT_W-1:0]  rx_idle_limit;
  logic [CNT_W-1:0]  half_bit_len;

  // mirrored link state
  link_phase_t       lphase;
  timer_act_t        timer_act;
  logic [CNT_W-1:0]  remain_ns;
  logic [CNT_W-1:0]  rearm_ns;
  logic [2:0]        bit_idx;
  logic [5:0]        byte_idx;
  logic [7:0]        frame_buf [FRAME_LEN];
  logic              scl_lv;
  logic              sda_lv;
  logic              lines_driven;

  out_item_t         expected_results [$];
  out_item_t         want;
  logic [DATA_W-1:0] reg_readback;
  int                n_err;
  int                n_res;
  int                n_frm;
  int                n_rej;
  int                n_tx;

  function automatic logic [1:0] mode_now();
    case (lphase)
      ST_IDLE: return MODE_IDLE;
      ST_RECV: return MODE_RECV;
      ST_LOAD: return MODE_LOAD;
      default: return MODE_XMIT;
    endcase
  endfunction

  function automatic out_item_t line_status(logic [7:0] b, logic v, logic l, logic rej);
    out_item_t r;
    r.scl_out       = scl_lv;
    r.sda_out       = sda_lv;
    r.drive_enable  = lines_driven;
    r.rx_byte       = b;
    r.rx_valid      = v;
    r.rx_last       = l;
    r.send_rejected = rej;
    r.link_mode     = mode_now();
    return r;
  endfunction

  function automatic string show(out_item_t r);
    return $sformatf("scl=%0b sda=%0b de=%0b byte=%02h valid=%0b last=%0b rej=%0b mode=%0d",
                     r.scl_out, r.sda_out, r.drive_enable, r.rx_byte, r.rx_valid,
                     r.rx_last, r.send_rejected, r.link_mode);
  endfunction

  task automatic note_failure(string msg);
    if (n_err < 10) $display("[%0t] %s", $realtime, msg);
    n_err++;
  endtask

  task automatic drop_frame();
    bit_idx  = '0;
    byte_idx = '0;
    foreach (frame_buf[k]) frame_buf[k] = '0;
  endtask

  // one clock phase of an outgoing frame
  task automatic clock_out_step();
    logic [7:0] b;
    if (lphase == ST_HIGH) begin
      b = (byte_idx < FRAME_LEN) ? frame_buf[int'(byte_idx)] : 8'h00;
      lphase  = ST_LOW;
      sda_lv  = b[bit_idx];
      scl_lv  = 1'b0;
      bit_idx = bit_idx + 3'd1;
      if (bit_idx == 3'd0) begin
        byte_idx = byte_idx + 6'd1;
        if (byte_idx >= FRAME_LEN) lphase = ST_LAST;
      end
      remain_ns = rearm_ns;
    end else if (lphase == ST_LOW) begin
      lphase    = ST_HIGH;
      scl_lv    = 1'b1;
      remain_ns = rearm_ns;
    end else begin
      // release the lines, countdown is left as it is
      drop_frame();
      timer_act    = ACT_NONE;
      lphase       = ST_IDLE;
      lines_driven = 1'b0;
      scl_lv       = 1'b1;
    end
  endtask

  task automatic predict(in_item_t it);
    logic [7:0] m;
    logic       done;
    done = 1'b0;
    case (it.func)
      FUNC_TICK: begin
        if (CNT_W'(tick_len) >= remain_ns) begin
          remain_ns = '0;
          if (timer_act == ACT_TIMEOUT) begin
            lphase    = ST_IDLE;
            timer_act = ACT_NONE;
            drop_frame();
          end else if (timer_act == ACT_SEND) begin
            if (lphase == ST_HIGH || lphase == ST_LOW || lphase == ST_LAST) clock_out_step();
            else timer_act = ACT_NONE;
          end
        end else begin
          remain_ns = remain_ns - CNT_W'(tick_len);
        end
      end
      FUNC_EDGE: begin
        if (lphase == ST_IDLE || lphase == ST_RECV) begin
          m         = 8'h01 << bit_idx;
          lphase    = ST_RECV;
          timer_act = ACT_TIMEOUT;
          rearm_ns  = rx_idle_limit;
          remain_ns = rx_idle_limit;
          if (byte_idx < FRAME_LEN) begin
            if (it.sda_level) frame_buf[int'(byte_idx)] = frame_buf[int'(byte_idx)] | m;
            else frame_buf[int'(byte_idx)] = frame_buf[int'(byte_idx)] & ~m;
          end
          bit_idx = bit_idx + 3'd1;
          if (bit_idx == 3'd0) byte_idx = byte_idx + 6'd1;
          if (byte_idx >= FRAME_LEN) begin
            // whole frame comes out as a burst, link stays in receive
            for (int k = 0; k < FRAME_LEN; k++)
              expected_results.push_back(line_status(frame_buf[k], 1'b1,
                                                     k == FRAME_LEN - 1, 1'b0));
            drop_frame();
            n_frm++;
            done = 1'b1;
          end
        end
      end
      FUNC_SEND: begin
        if (lphase == ST_IDLE || lphase == ST_LOAD) begin
          if (lphase == ST_IDLE) begin
            lphase       = ST_LOAD;
            bit_idx      = '0;
            frame_buf[0] = it.send_byte;
            byte_idx     = 6'd1;
          end else begin
            if (byte_idx < FRAME_LEN) frame_buf[int'(byte_idx)] = it.send_byte;
            byte_idx = byte_idx + 6'd1;
          end
          if (byte_idx >= FRAME_LEN) begin
            lphase       = ST_HIGH;
            lines_driven = 1'b1;
            bit_idx      = '0;
            byte_idx     = '0;
            timer_act    = ACT_SEND;
            rearm_ns     = half_bit_len;
            remain_ns    = '0;
            n_tx++;
          end
        end else begin
          expected_results.push_back(line_status(8'h00, 1'b0, 1'b0, 1'b1));
          n_rej++;
          done = 1'b1;
        end
      end
      default: ;
    endcase
    if (!done) expected_results.push_back(line_status(8'h00, 1'b0, 1'b0, 1'b0));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tick_len      = TICK_NS_RST;
      rx_idle_limit = RX_TIMEOUT_NS_RST;
      half_bit_len  = BIT_HALF_NS_RST;
      lphase        = ST_IDLE;
      timer_act     = ACT_NONE;
      remain_ns     = '0;
      rearm_ns      = '0;
      drop_frame();
      scl_lv        = 1'b1;
      sda_lv        = 1'b1;
      lines_driven  = 1'b0;
      expected_results.delete();
      n_err = 0;
      n_res = 0;
      n_frm = 0;
      n_rej = 0;
      n_tx  = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[ADDR_W-1:2])
            REG_TICK_NS:       tick_len      = pwdata[TICK_W-1:0];
            REG_RX_TIMEOUT_NS: rx_idle_limit = pwdata[CNT_W-1:0];
            REG_BIT_HALF_NS:   half_bit_len  = pwdata[CNT_W-1:0];
            default: ;
          endcase
        end else begin
          case (paddr[ADDR_W-1:2])
            REG_TICK_NS:       reg_readback = DATA_W'(tick_len);
            REG_RX_TIMEOUT_NS: reg_readback = DATA_W'(rx_idle_limit);
            default:           reg_readback = DATA_W'(half_bit_len);
          endcase
          if (prdata !== reg_readback)
            note_failure($sformatf("register read at %0h: expected %0h, got %0h",
                                   paddr, reg_readback, prdata));
        end
      end
      if (out_valid && out_ready) begin
        n_res++;
        if (expected_results.size() == 0) begin
          note_failure({"unexpected result: ", show(out_data)});
        end else begin
          want = expected_results.pop_front();
          if (out_data.scl_out !== want.scl_out || out_data.sda_out !== want.sda_out ||
              out_data.drive_enable !== want.drive_enable ||
              out_data.rx_byte !== want.rx_byte || out_data.rx_valid !== want.rx_valid ||
              out_data.rx_last !== want.rx_last ||
              out_data.send_rejected !== want.send_rejected ||
              out_data.link_mode !== want.link_mode)
            note_failure($sformatf("result %0d mismatch\n  expected %s\n  actual   %s",
                                   n_res, show(want), show(out_data)));
        end
      end
      if (in_valid && in_ready) predict(in_data);
    end
    pending      <= expected_results.size();
    link_idle    <= (lphase == ST_IDLE);
    link_loading <= (lphase == ST_LOAD);
    fail_count   <= n_err;
    result_count <= n_res;
    frame_count  <= n_frm;
    reject_count <= n_rej;
    xmit_count   <= n_tx;
  end

endmodule

>>> tb/two_wire_frame_transceiver_unit_tb.sv
// testbench top for the two-wire frame transceiver: stimulus, stalls and verdict
`timescale 1ns / 100ps
module two_wire_frame_transceiver_unit_tb;
  import tfx_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS   = 70;

  localparam int STALL_NONE  = 0;
  localparam int STALL_COIN  = 1;
  localparam int STALL_COMB  = 2;
  localparam int STALL_HEAVY = 3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int   fail_count;
  int   pending;
  logic link_idle;
  logic link_loading;
  int   result_count;
  int   frame_count;
  int   reject_count;
  int   xmit_count;

  int cycles = 0;
  int n_items = 0;
  int n_settings = 0;
  int burst_left = 0;
  int stall_kind = STALL_NONE;
  int stall_left = 0;

  // current register values in ticks
  int ticks_to_timeout;
  int ticks_per_half;

  two_wire_frame_transceiver_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  tfx_checker i_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .pending      (pending),
    .link_idle    (link_idle),
    .link_loading (link_loading),
    .result_count (result_count),
    .frame_count  (frame_count),
    .reject_count (reject_count),
    .xmit_count   (xmit_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("cycle limit of %0d reached with %0d results outstanding", CYCLE_LIMIT, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: switches to a randomly chosen stall pattern whenever its countdown runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_kind <= $urandom_range(STALL_NONE, STALL_HEAVY);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_kind)
      STALL_NONE:  out_ready <= 1'b1;
      STALL_COIN:  out_ready <= ($urandom_range(0, 1) == 0);
      STALL_COMB:  out_ready <= (stall_left % 5 != 0);
      default:     out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // one input transaction; the sender runs in bursts with idle gaps between
  task automatic put_item(logic [1:0] f, logic s, logic [7:0] b);
    in_item_t it;
    if (burst_left == 0)
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    it.func      = f;
    it.sda_level = s;
    it.send_byte = b;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    n_items++;
    burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic put_noise_tick();
    put_item(FUNC_TICK, 1'($urandom), 8'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // push the link back to idle: finish a load, then tick until released
  task automatic drive_link_idle();
    wait_drained();
    while (!link_idle) begin
      if (link_loading) put_item(FUNC_SEND, 1'($urandom), 8'($urandom));
      else put_noise_tick();
      wait_drained();
    end
  endtask

  task automatic apb_write(logic [1:0] idx, logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(logic [1:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(int t, int to, int h);
    apb_write(REG_TICK_NS, DATA_W'(t));
    apb_write(REG_RX_TIMEOUT_NS, DATA_W'(to));
    apb_write(REG_BIT_HALF_NS, DATA_W'(h));
    apb_read(REG_TICK_NS);
    apb_read(REG_RX_TIMEOUT_NS);
    apb_read(REG_BIT_HALF_NS);
    ticks_to_timeout = (to + t - 1) / t;
    ticks_per_half   = (h + t - 1) / t;
    n_settings++;
  endtask

  task automatic random_config();
    int t;
    int to;
    int h;
    case ($urandom_range(0, 2))
      0:       t = $urandom_range(1, 1000);
      1:       t = $urandom_range(1, 1000000);
      default: t = $urandom_range(1000, 50000);
    endcase
    to = t * $urandom_range(1, 30) - $urandom_range(0, t - 1);
    h  = t * $urandom_range(1, 2) - $urandom_range(0, t - 1);
    if (to > 16777215) to = 16777215;
    if (h > 16777215) h = 16777215;
    if (to < 1) to = 1;
    if (h < 1) h = 1;
    set_config(t, to, h);
  endtask

  // a received frame of nedges clock edges, with harmless noise in between
  task automatic rx_frame(int nedges, bit end_with_timeout);
    int r;
    for (int i = 0; i < nedges; i++) begin
      r = $urandom_range(0, 99);
      if (i > 0) begin
        // ticks stay short of the timeout, edges re-arm it
        if (r < 8 && ticks_to_timeout > 1)
          repeat ($urandom_range(1, ticks_to_timeout - 1)) put_noise_tick();
        else if (r < 11) put_item(FUNC_SEND, 1'($urandom), 8'($urandom));
        else if (r < 13) put_item(FUNC_UNUSED, 1'($urandom), 8'($urandom));
      end
      put_item(FUNC_EDGE, 1'($urandom), 8'($urandom));
    end
    if (end_with_timeout) repeat (ticks_to_timeout) put_noise_tick();
  endtask

  // load a whole frame, then tick it out
  task automatic tx_frame();
    int r;
    int nticks;
    for (int i = 0; i < FRAME_LEN; i++) begin
      r = $urandom_range(0, 99);
      if (i > 0) begin
        if (r < 5) put_item(FUNC_EDGE, 1'($urandom), 8'($urandom));
        else if (r < 8) put_noise_tick();
        else if (r < 10) put_item(FUNC_UNUSED, 1'($urandom), 8'($urandom));
      end
      put_item(FUNC_SEND, 1'($urandom), 8'($urandom));
    end
    // first tick starts at once, every later phase waits out the half period
    nticks = 1 + (FRAME_LEN * 16 - 1) * ticks_per_half;
    for (int j = 0; j < nticks; j++) begin
      r = $urandom_range(0, 99);
      if (r < 2) put_item(FUNC_EDGE, 1'($urandom), 8'($urandom));
      else if (r < 4) put_item(FUNC_SEND, 1'($urandom), 8'($urandom));
      else if (r < 5) put_item(FUNC_UNUSED, 1'($urandom), 8'($urandom));
      put_noise_tick();
    end
  endtask

  task automatic run_phase();
    int start;
    int pick;
    start = n_items;
    while (n_items - start < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        rx_frame(FRAME_LEN * 8, $urandom_range(0, 2) != 0);
      end else if (pick < 60) begin
        rx_frame($urandom_range(1, FRAME_LEN * 8 - 1), 1'b1);
      end else if (pick < 85) begin
        tx_frame();
      end else begin
        repeat ($urandom_range(3, 12))
          put_item(2'($urandom_range(0, 3)), 1'($urandom), 8'($urandom));
        drive_link_idle();
      end
    end
    drive_link_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // registers must come up at their defaults
    apb_read(REG_TICK_NS);
    apb_read(REG_RX_TIMEOUT_NS);
    apb_read(REG_BIT_HALF_NS);

    // directed: a 1000000 ns tick, single-tick timeout and half period
    set_config(1000000, 1, 1);
    put_item(FUNC_TICK, 1'b0, 8'h00);
    put_item(FUNC_UNUSED, 1'b1, 8'hFF);
    put_item(FUNC_EDGE, 1'b1, 8'h00);
    put_item(FUNC_EDGE, 1'b0, 8'hFF);
    put_item(FUNC_SEND, 1'b0, 8'h00);
    put_item(FUNC_UNUSED, 1'b0, 8'h00);
    put_item(FUNC_TICK, 1'b1, 8'hFF);
    // load with edges and ticks mixed in, both ignored
    put_item(FUNC_SEND, 1'b0, 8'h00);
    put_item(FUNC_EDGE, 1'b1, 8'h00);
    put_item(FUNC_SEND, 1'b1, 8'hFF);
    put_item(FUNC_TICK, 1'b0, 8'h00);
    put_item(FUNC_SEND, 1'b0, 8'h80);
    put_item(FUNC_SEND, 1'b0, 8'h01);
    put_item(FUNC_SEND, 1'b0, 8'h7F);
    put_item(FUNC_SEND, 1'b0, 8'hFE);
    put_item(FUNC_SEND, 1'b0, 8'h55);
    put_item(FUNC_SEND, 1'b0, 8'hAA);
    put_item(FUNC_SEND, 1'b1, 8'h0F);
    put_item(FUNC_SEND, 1'b1, 8'hF0);
    put_item(FUNC_SEND, 1'b1, 8'h3C);
    put_item(FUNC_SEND, 1'b1, 8'hC3);
    // first tick starts the clock, then reject and ignore while sending
    put_item(FUNC_TICK, 1'b0, 8'h00);
    put_item(FUNC_SEND, 1'b0, 8'h5A);
    put_item(FUNC_EDGE, 1'b1, 8'h00);
    put_item(FUNC_UNUSED, 1'b1, 8'h00);
    drive_link_idle();

    set_config(1, 1, 1);
    run_phase();
    // largest timeout and half period values: a short partial frame left to time out
    set_config(1000000, 16777215, 16777215);
    rx_frame(5, 1'b1);
    drive_link_idle();
    random_config();
    run_phase();

    wait_drained();
    repeat (16) @(posedge clk);
    $display("covered %0d input transactions and %0d results over %0d register settings",
             n_items, result_count, n_settings);
    $display("frames received: %0d, frames sent: %0d, sends rejected: %0d",
             frame_count, xmit_count, reject_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fail_count, pending);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/tfx_pkg.sv
design/tfx_regs.sv
design/tfx_ctrl.sv
design/tfx_dpath.sv
design/two_wire_frame_transceiver_unit.sv
tb/tfx_checker.sv
tb/two_wire_frame_transceiver_unit_tb.sv
